// File: design/uri_percent_codec_macros.svh
// Assertion macros used by the percent codec RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef URI_PERCENT_CODEC_MACROS_SVH
`define URI_PERCENT_CODEC_MACROS_SVH

// same-cycle implication
`define UPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upc check failed");

// next-cycle implication
`define UPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upc check failed");

`endif

// File: design/upc_pkg.sv
// Package for the percent codec: types, constants, escape sets, hex helpers.
// No dependencies.
`timescale 1ns / 1ps

package upc_pkg;

  localparam logic [7:0] PCT_CHAR       = 8'h25;
  localparam int         MODE_W         = 2;
  localparam int         MODE_UNESC_BIT = 1;
  localparam int         MODE_DATA_BIT  = 0;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_t;

  typedef struct packed {
    logic [1:0]      count;
    logic            last;
    logic [2:0][7:0] bytes;
  } upc_group_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic logic in_uri_set(input logic [7:0] b);
    return (b <= 8'd32) || (b == 8'd34) || (b == 8'd37) || (b == 8'd60) ||
           (b == 8'd62) || (b == 8'd92) || (b == 8'd94) ||
           ((b >= 8'd123) && (b <= 8'd125)) || (b >= 8'd127);
  endfunction

  function automatic logic in_data_set(input logic [7:0] b);
    return (b <= 8'd43) || (b == 8'd46) || ((b >= 8'd58) && (b <= 8'd64)) ||
           ((b >= 8'd91) && (b <= 8'd94)) || (b == 8'd96) ||
           ((b >= 8'd123) && (b <= 8'd125)) || (b >= 8'd127);
  endfunction

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.nib = 4'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      h.ok  = 1'b1;
      h.nib = c[3:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      h.ok  = 1'b1;
      h.nib = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  function automatic logic [7:0] hex_upper(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

endpackage

// File: design/upc_in_if.sv
// Input request channel of the percent codec: one byte and a last flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface upc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: design/upc_out_if.sv
// Output request channel of the percent codec: one byte and a last flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface upc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: design/upc_decode.sv
// Per-byte decision logic and held-escape state of the percent codec.
// Depends on upc_pkg.
`timescale 1ns / 1ps

module upc_decode (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [upc_pkg::MODE_W-1:0] mode,
  input  logic                       accept,
  input  logic [7:0]                 in_byte,
  input  logic                       in_last,
  output upc_pkg::upc_group_t        grp
);

  upc_pkg::held_t held_count;
  upc_pkg::held_t held_count_next;
  logic [7:0]     held_digit;
  logic [7:0]     held_digit_next;

  upc_pkg::hex_t hi;
  upc_pkg::hex_t lo;
  logic          esc;
  logic          is_pct;

  always_comb begin
    hi     = upc_pkg::hex_value(held_digit);
    lo     = upc_pkg::hex_value(in_byte);
    is_pct = (in_byte == upc_pkg::PCT_CHAR);
    esc    = mode[upc_pkg::MODE_DATA_BIT] ? upc_pkg::in_data_set(in_byte)
                                          : upc_pkg::in_uri_set(in_byte);
    grp             = '0;
    held_count_next = held_count;
    held_digit_next = held_digit;
    if (!mode[upc_pkg::MODE_UNESC_BIT]) begin
      held_count_next = upc_pkg::HELD_NONE;
      if (esc) begin
        grp.count    = 2'd3;
        grp.bytes[0] = upc_pkg::PCT_CHAR;
        grp.bytes[1] = upc_pkg::hex_upper(in_byte[7:4]);
        grp.bytes[2] = upc_pkg::hex_upper(in_byte[3:0]);
      end else begin
        grp.count    = 2'd1;
        grp.bytes[0] = in_byte;
      end
    end else begin
      case (held_count)
        upc_pkg::HELD_NONE: begin
          if (is_pct && !in_last) begin
            held_count_next = upc_pkg::HELD_PCT;
          end else begin
            grp.count    = 2'd1;
            grp.bytes[0] = in_byte;
          end
        end
        upc_pkg::HELD_PCT: begin
          held_count_next = upc_pkg::HELD_NONE;
          if (is_pct) begin
            grp.count    = 2'd1;
            grp.bytes[0] = upc_pkg::PCT_CHAR;
          end else if (lo.ok && !in_last) begin
            held_digit_next = in_byte;
            held_count_next = upc_pkg::HELD_DIGIT;
          end else begin
            grp.count    = 2'd2;
            grp.bytes[0] = upc_pkg::PCT_CHAR;
            grp.bytes[1] = in_byte;
          end
        end
        upc_pkg::HELD_DIGIT: begin
          held_count_next = upc_pkg::HELD_NONE;
          if (hi.ok && lo.ok) begin
            grp.count    = 2'd1;
            grp.bytes[0] = {hi.nib, lo.nib};
          end else begin
            grp.bytes[0] = upc_pkg::PCT_CHAR;
            grp.bytes[1] = held_digit;
            if (is_pct && !in_last) begin
              grp.count       = 2'd2;
              held_count_next = upc_pkg::HELD_PCT;
            end else begin
              grp.count    = 2'd3;
              grp.bytes[2] = in_byte;
            end
          end
        end
        default: begin
          held_count_next = upc_pkg::HELD_NONE;
          grp.count       = 2'd1;
          grp.bytes[0]    = in_byte;
        end
      endcase
    end
    if (in_last) begin
      held_count_next = upc_pkg::HELD_NONE;
      grp.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= upc_pkg::HELD_NONE;
      held_digit <= 8'd0;
    end else if (accept) begin
      held_count <= held_count_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

// File: design/upc_serializer.sv
// Result register of the percent codec; sends up to three bytes per item.
// Depends on upc_pkg, upc_out_if and uri_percent_codec_macros.svh.
`timescale 1ns / 1ps
`include "uri_percent_codec_macros.svh"

module upc_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  upc_pkg::upc_group_t grp_in,
  output logic                free,
  upc_out_if.source           result
);

  upc_pkg::upc_group_t grp;
  logic                grp_valid;
  logic [1:0]          grp_idx;
  logic                at_end;
  logic                out_fire;
  logic                load;

  assign at_end   = (grp_idx == (grp.count - 2'd1));
  assign out_fire = grp_valid && result.ready;
  assign free     = !grp_valid || (result.ready && at_end);
  assign load     = accept && (grp_in.count != 2'd0);

  assign result.valid    = grp_valid;
  assign result.out_last = grp.last && at_end;

  always_comb begin
    case (grp_idx)
      2'd0:    result.out_byte = grp.bytes[0];
      2'd1:    result.out_byte = grp.bytes[1];
      2'd2:    result.out_byte = grp.bytes[2];
      default: result.out_byte = grp.bytes[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      grp_idx   <= 2'd0;
    end else if (load) begin
      grp_valid <= 1'b1;
      grp_idx   <= 2'd0;
    end else if (out_fire) begin
      if (at_end) begin
        grp_valid <= 1'b0;
        grp_idx   <= 2'd0;
      end else begin
        grp_idx <= grp_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  `UPC_ASSERT_NOW(a_count_nonzero, clk, rst, grp_valid, grp.count != 2'd0)
  `UPC_ASSERT_NOW(a_idx_in_range, clk, rst, grp_valid, grp_idx < grp.count)
  `UPC_ASSERT_NEXT(a_load_starts, clk, rst, load, grp_valid && grp_idx == 2'd0)
  `UPC_ASSERT_NEXT(a_stall_holds, clk, rst, grp_valid && !result.ready, grp_valid && $stable(grp_idx))

endmodule

// File: design/uri_percent_codec.sv
// The first result byte is valid in the cycle after its input request is taken.
// Throughput: one request per cycle for one-byte items while result.ready is high;
//   escapes and failed escapes send up to 3 bytes in turn from the result register.
// Items that only hold a '%' or digit give no bytes.
// Reset (rst, synchronous): mode = escape with URI set, nothing held, no result.
`timescale 1ns / 1ps

module uri_percent_codec (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [upc_pkg::MODE_W-1:0] cfg_wdata,
  upc_in_if.sink                     feed,
  upc_out_if.source                  result
);

  logic [upc_pkg::MODE_W-1:0] mode;
  logic                       accept;
  logic                       free;
  upc_pkg::upc_group_t        grp;

  assign feed.ready = free;
  assign accept     = feed.valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= upc_pkg::MODE_RESET;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  upc_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .mode    (mode),
    .accept  (accept),
    .in_byte (feed.in_byte),
    .in_last (feed.in_last),
    .grp     (grp)
  );

  upc_serializer u_serializer (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .grp_in (grp),
    .free   (free),
    .result (result)
  );

endmodule

// File: test/tb_top.sv
// Testbench for uri_percent_codec: directed and random strings in every mode, with a
// local predictor of the percent escape and unescape rules.
// Depends on upc_pkg, upc_in_if, upc_out_if and the codec RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int MODE_W = upc_pkg::MODE_W;
  localparam logic [MODE_W-1:0] MODE_URI       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DATA      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNESC     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNESC_ALT = 2'd3;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_wdata;

  upc_in_if  feed_if();
  upc_out_if result_if();

  uri_percent_codec uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .feed(feed_if),
    .result(result_if)
  );

  logic [MODE_W-1:0] model_mode;
  upc_pkg::held_t    model_held;
  logic [7:0]        model_digit;
  out_char_t         expected_chars[$];
  logic [7:0]        text_buf[$];
  int                errors = 0;
  int                quiet_cycles = 0;
  int                feed_gap_pct;
  int                stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic uri_escaped(input logic [7:0] b);
    return b <= 8'd32 || b == 8'd34 || b == 8'd37 || b == 8'd60 || b == 8'd62 ||
           b == 8'd92 || b == 8'd94 || (b >= 8'd123 && b <= 8'd125) || b >= 8'd127;
  endfunction

  function automatic logic data_escaped(input logic [7:0] b);
    return b <= 8'd43 || b == 8'd46 || (b >= 8'd58 && b <= 8'd64) ||
           (b >= 8'd91 && b <= 8'd94) || b == 8'd96 ||
           (b >= 8'd123 && b <= 8'd125) || b >= 8'd127;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] digit_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - 8'h30)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h37)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h57)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
  endfunction

  function automatic void convert_byte(input logic [7:0] b, input logic last);
    logic [7:0] outs[$];
    logic [4:0] hi;
    logic [4:0] lo;
    logic       esc;
    lo = digit_val(b);
    if (!model_mode[upc_pkg::MODE_UNESC_BIT]) begin
      esc = model_mode[upc_pkg::MODE_DATA_BIT] ? data_escaped(b) : uri_escaped(b);
      model_held = upc_pkg::HELD_NONE;
      if (esc) begin
        outs.push_back(upc_pkg::PCT_CHAR);
        outs.push_back(hex_char(b[7:4]));
        outs.push_back(hex_char(b[3:0]));
      end else begin
        outs.push_back(b);
      end
    end else if (model_held == upc_pkg::HELD_NONE) begin
      if (b == upc_pkg::PCT_CHAR && !last) begin
        model_held = upc_pkg::HELD_PCT;
      end else begin
        outs.push_back(b);
      end
    end else if (model_held == upc_pkg::HELD_PCT) begin
      if (b == upc_pkg::PCT_CHAR) begin
        outs.push_back(upc_pkg::PCT_CHAR);
        model_held = upc_pkg::HELD_NONE;
      end else if (lo[4] && !last) begin
        model_digit = b;
        model_held = upc_pkg::HELD_DIGIT;
      end else begin
        outs.push_back(upc_pkg::PCT_CHAR);
        outs.push_back(b);
        model_held = upc_pkg::HELD_NONE;
      end
    end else begin
      hi = digit_val(model_digit);
      model_held = upc_pkg::HELD_NONE;
      if (hi[4] && lo[4]) begin
        outs.push_back({hi[3:0], lo[3:0]});
      end else begin
        // failed escape: emit what was held, then look at this byte again
        outs.push_back(upc_pkg::PCT_CHAR);
        outs.push_back(model_digit);
        if (b == upc_pkg::PCT_CHAR && !last) begin
          model_held = upc_pkg::HELD_PCT;
        end else begin
          outs.push_back(b);
        end
      end
    end
    if (last) model_held = upc_pkg::HELD_NONE;
    foreach (outs[i]) begin
      expected_chars.push_back('{ch: outs[i], last: last && (i == outs.size() - 1)});
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t ns: %s mismatch, expected %02h got %02h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    out_char_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected out_byte", 8'h00, result_if.out_byte);
      end else begin
        want = expected_chars.pop_front();
        if (result_if.out_byte !== want.ch)
          report_mismatch("out_byte", want.ch, result_if.out_byte);
        if (result_if.out_last !== want.last)
          report_mismatch("out_last", 8'(want.last), 8'(result_if.out_last));
      end
    end
  end

  always @(posedge clk) begin
    result_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((feed_if.valid && feed_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no request moved for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < feed_gap_pct) begin
      feed_if.valid <= 1'b0;
      @(posedge clk);
    end
    feed_if.valid   <= 1'b1;
    feed_if.in_byte <= b;
    feed_if.in_last <= last;
    do @(posedge clk); while (!feed_if.ready);
    convert_byte(b, last);
  endtask

  task automatic send_text(input logic close);
    foreach (text_buf[i]) send_item(text_buf[i], close && (i == text_buf.size() - 1));
  endtask

  task automatic load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic wait_results_done();
    feed_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    wait_results_done();
    // a held '%' or digit gives no byte, so let the block settle first
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    model_mode = m;
  endtask

  task automatic test_uri_escape();
    write_mode(MODE_URI);
    text_buf = '{8'h00, upc_pkg::PCT_CHAR, "A", "~", 8'hFF};
    send_text(1'b1);
  endtask

  task automatic test_data_escape();
    write_mode(MODE_DATA);
    text_buf = '{".", "z", 8'h7F, 8'h80, 8'hFF};
    send_text(1'b1);
  endtask

  task automatic test_unescape();
    write_mode(MODE_UNESC);
    load_text("%7E%%%4g%");
    send_text(1'b1);
    load_text("%4");
    send_text(1'b1);
  endtask

  task automatic test_mode_three();
    write_mode(MODE_UNESC_ALT);
    load_text("%3fq");
    send_text(1'b1);
    // leave a '%' held, then escape mode must drop it
    send_item(upc_pkg::PCT_CHAR, 1'b0);
    write_mode(MODE_URI);
    send_item("A", 1'b1);
  endtask

  function automatic logic [7:0] rand_hex_char();
    logic [3:0] n;
    n = 4'($urandom_range(15));
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h37 : 8'h57) + 8'(n);
  endfunction

  task automatic build_unescape_text(input int len);
    text_buf.delete();
    while (text_buf.size() < len) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          text_buf.push_back(upc_pkg::PCT_CHAR);
          text_buf.push_back(rand_hex_char());
          text_buf.push_back(rand_hex_char());
        end
        5: begin
          text_buf.push_back(upc_pkg::PCT_CHAR);
          text_buf.push_back(upc_pkg::PCT_CHAR);
        end
        6: begin
          text_buf.push_back(upc_pkg::PCT_CHAR);
          text_buf.push_back(8'($urandom_range(255)));
        end
        7: begin
          text_buf.push_back(upc_pkg::PCT_CHAR);
          text_buf.push_back(rand_hex_char());
          text_buf.push_back(8'($urandom_range(255)));
        end
        default: text_buf.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic build_escape_text(input int len);
    text_buf.delete();
    repeat (len) begin
      if ($urandom_range(1)) text_buf.push_back(8'($urandom_range(255)));
      else text_buf.push_back(8'($urandom_range(126, 32)));
    end
  endtask

  task automatic test_random_traffic(input int count);
    int sent;
    int len;
    logic [MODE_W-1:0] m;
    sent = 0;
    while (sent < count) begin
      m = MODE_W'($urandom_range(3));
      write_mode(m);
      len = int'($urandom_range(16, 4));
      if (len > count - sent) len = count - sent;
      if (m[upc_pkg::MODE_UNESC_BIT]) build_unescape_text(len);
      else build_escape_text(len);
      // an unterminated string now and then leaves state across the mode write
      send_text($urandom_range(7) != 0);
      sent += text_buf.size();
    end
  endtask

  initial begin
    feed_gap_pct  = 6;
    stall_pct     = 61;
    model_mode    = upc_pkg::MODE_RESET;
    model_held    = upc_pkg::HELD_NONE;
    model_digit   = 8'h00;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= upc_pkg::MODE_RESET;
    feed_if.valid   <= 1'b0;
    feed_if.in_byte <= 8'h00;
    feed_if.in_last <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_uri_escape();
    test_data_escape();
    test_unescape();
    test_mode_three();
    test_random_traffic(28);

    feed_gap_pct = 61;
    stall_pct    = 6;
    test_random_traffic(28);

    feed_gap_pct = 0;
    stall_pct    = 0;
    test_random_traffic(28);

    wait_results_done();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
